FILE: rtl/rleifd_pkg.sv
// ---------------------------------------------------------------------------
// rleifd_pkg: shared types and constants of the intra-frame RLE decoder
// Field widths, register indexes, limits of the position counters and the
// structs that pass between the decoder's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rleifd_pkg;

    // Largest frame the decoder is built for.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths.
    localparam int CODE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int COUNT_W = 9;
    localparam int COLOR_W = 8;
    localparam int WIDTH_W = 11;
    localparam int INDEX_W = 2;

    // Column wrap limit cap and the row at which the row counter saturates.
    localparam int WRAP_CAP = (MAX_WIDTH > 1024) ? 1024 : MAX_WIDTH;
    localparam int LAST_ROW = ((MAX_HEIGHT > 1024) ? 1024 : MAX_HEIGHT) - 1;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [INDEX_W-1:0] REG_DOUBLE_HORZ = 2'd1;
    localparam logic [INDEX_W-1:0] REG_DOUBLE_VERT = 2'd2;

    // Reset value of the frame width register.
    localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RESET = 11'd320;

    // Current configuration as seen by the decode core.
    typedef struct packed {
        logic [WIDTH_W-1:0] frame_width;
        logic               double_horizontal;
        logic               double_vertical;
    } cfg_t;

    // One fill command.
    typedef struct packed {
        logic               two_rows;
        logic [COLOR_W-1:0] fill_color;
        logic [COUNT_W-1:0] pixel_count;
        logic [ROW_W-1:0]   start_row;
        logic [COL_W-1:0]   start_column;
    } fill_t;

endpackage

`default_nettype wire

FILE: rtl/rleifd_core.sv
// ---------------------------------------------------------------------------
// rleifd_core: byte decode and frame position tracking
// Holds the column, row and pending run count, decodes one code byte per
// advance and produces the fill command that the byte completes.
// ---------------------------------------------------------------------------
`default_nettype none

module rleifd_core
    import rleifd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic [CODE_W-1:0]  code_byte,
    input  wire logic               frame_start,
    input  wire cfg_t               cfg,
    output fill_t                   fill,
    output logic                    fill_valid
);

    logic [COL_W-1:0]   column_reg,   column_next;
    logic [ROW_W-1:0]   row_reg,      row_next;
    logic               awaiting_reg, awaiting_next;
    logic [RUN_W-1:0]   pending_reg,  pending_next;

    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic               awaiting_cur;
    logic [RUN_W-1:0]   pending_cur;
    logic               run_done;
    logic [RUN_W:0]     run_len;
    logic [COUNT_W-1:0] count;
    logic [WIDTH_W-1:0] wrap_lim;
    logic [WIDTH_W-1:0] col_sum;
    logic [WIDTH_W-1:0] row_sum;

    // A frame start clears the position and the pending count before the byte is decoded.
    always_comb begin
        col_cur      = frame_start ? '0 : column_reg;
        row_cur      = frame_start ? '0 : row_reg;
        awaiting_cur = frame_start ? 1'b0 : awaiting_reg;
        pending_cur  = frame_start ? '0 : pending_reg;
    end

    // Byte decode: color after a count, literal pixel, or a new count.
    always_comb begin
        run_done = 1'b1;
        run_len  = (RUN_W+1)'(1);
        if (awaiting_cur) begin
            run_len = {1'b0, pending_cur} + (RUN_W+1)'(2);
        end else if (!code_byte[CODE_W-1]) begin
            run_done = 1'b0;
        end
        count = cfg.double_horizontal ? {run_len, 1'b0} : {1'b0, run_len};
    end

    // Fill command for a completed, non-transparent run.
    always_comb begin
        fill.start_column = col_cur;
        fill.start_row    = row_cur;
        fill.pixel_count  = count;
        fill.fill_color   = code_byte;
        fill.two_rows     = cfg.double_vertical;
        fill_valid        = run_done && (code_byte != '0);
    end

    // Position advance with column wrap and row saturation, or a new pending count.
    always_comb begin
        wrap_lim = (cfg.frame_width > WIDTH_W'(WRAP_CAP)) ? WIDTH_W'(WRAP_CAP)
                                                          : cfg.frame_width;
        col_sum  = {1'b0, col_cur} + {2'b00, count};
        row_sum  = {1'b0, row_cur} + WIDTH_W'(1) + {10'd0, cfg.double_vertical};

        column_next   = col_cur;
        row_next      = row_cur;
        awaiting_next = awaiting_cur;
        pending_next  = pending_cur;
        if (run_done) begin
            awaiting_next = 1'b0;
            if (col_sum >= wrap_lim) begin
                column_next = '0;
                row_next    = (row_sum > WIDTH_W'(LAST_ROW)) ? ROW_W'(LAST_ROW)
                                                             : row_sum[ROW_W-1:0];
            end else begin
                column_next = col_sum[COL_W-1:0];
            end
        end else begin
            awaiting_next = 1'b1;
            pending_next  = code_byte[RUN_W-1:0];
        end
    end

    // State registers, updated once per decoded byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            row_reg      <= '0;
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
        end else if (advance) begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rle_intra_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// rle_intra_frame_decoder_top: run-length decoder for 8-bit intra frames
// Turns the code bytes of an intra-coded palettized frame into fill
// commands (start position, pixel count, color, two-row flag).
//
//   Channel   Direction  Payload
//   s_*       in         tdata: code_byte; tuser: frame_start
//   m_*       out        tdata: start_column, start_row, pixel_count,
//                               fill_color; tuser: two_rows
//   cfg_*     in         cfg_index selects the register, cfg_data is written
//
// One byte is accepted per cycle while m_* does not stall; a byte waits in
// the input register until the result register can take it, and its fill
// then shows on m_*. The core updates the position as the byte moves on.
// Reset (aresetn low, synchronous) empties both registers, clears the
// position and loads the register defaults. A stall on m_tready holds the
// result and backs up into s_tready once the input register is also full.
// ---------------------------------------------------------------------------
`default_nettype none

module rle_intra_frame_decoder_top
    import rleifd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Code byte stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] code_byte
    input  wire logic                s_tuser,   // [0] frame_start
    // Fill command stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [9:0] start_column, [19:10] start_row, [28:20] pixel_count,
    // [36:29] fill_color, [39:37] zero
    output logic [39:0]              m_tdata,
    output logic                     m_tuser,   // [0] two_rows
    // Configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [INDEX_W-1:0]  cfg_index,
    input  wire logic [WIDTH_W-1:0]  cfg_data
);

    logic               in_valid_reg;
    logic [CODE_W-1:0]  in_code_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    fill_t              out_fill_reg;
    cfg_t               cfg_reg;
    logic               advance;
    fill_t              fill;
    logic               fill_valid;

    // Handshake: the input register moves on when the result slot frees.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width       <= FRAME_WIDTH_RESET;
            cfg_reg.double_horizontal <= 1'b0;
            cfg_reg.double_vertical   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH: cfg_reg.frame_width       <= cfg_data;
                REG_DOUBLE_HORZ: cfg_reg.double_horizontal <= cfg_data[0];
                REG_DOUBLE_VERT: cfg_reg.double_vertical   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // Decode core with the position state.
    rleifd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .code_byte   (in_code_reg),
        .frame_start (in_start_reg),
        .cfg         (cfg_reg),
        .fill        (fill),
        .fill_valid  (fill_valid)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fill_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_fill_reg <= fill;
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_fill_reg.fill_color, out_fill_reg.pixel_count,
                       out_fill_reg.start_row, out_fill_reg.start_column};
    assign m_tuser  = out_fill_reg.two_rows;

endmodule

`default_nettype wire
